// File: rtl/jla_pkg.sv
// shared types, constants and helper functions of the joint limit align block
package jla_pkg;

  localparam int ANGLE_BITS      = 32;
  localparam int WIDE_BITS       = ANGLE_BITS + 4;
  localparam int JOINT_BITS      = 3;
  localparam int JOINT_COUNT_DEF = 6;
  localparam int CAND_COUNT      = 5;
  localparam int KSEL_BITS       = 3;
  localparam int RECIP_SHIFT     = 34;
  localparam int QUO_BITS        = 64 - RECIP_SHIFT;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  // full turn, 2*pi with 24 fraction bits
  localparam wide_t  TWO_PI_FX    = WIDE_BITS'(105414357);
  localparam angle_t LIMIT_LO_RST = -ANGLE_BITS'(105414357);
  localparam angle_t LIMIT_HI_RST = ANGLE_BITS'(105414357);
  // floor(y / 5) = (y * RECIP_FIVE) >> RECIP_SHIFT for any 32-bit y
  localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;
  localparam logic [KSEL_BITS-1:0] KSEL_CENTER = KSEL_BITS'(2);

  typedef enum logic [1:0] {
    CMD_CLAMP   = 2'd0,
    CMD_REBOUND = 2'd1,
    CMD_ALIGN   = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [JOINT_BITS-1:0] joint_index;
    angle_t                angle_in;
    angle_t                reference_angle;
    angle_t                new_lower;
    angle_t                new_upper;
  } in_item_t;

  typedef struct packed {
    angle_t                angle_out;
    logic [JOINT_BITS-1:0] joint_out;
  } out_item_t;

  function automatic wide_t widen(input angle_t a);
    return {{(WIDE_BITS-ANGLE_BITS){a[ANGLE_BITS-1]}}, a};
  endfunction

  function automatic angle_t sat_angle(input wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = widen({1'b0, {(ANGLE_BITS-1){1'b1}}});
    lo_lim = widen({1'b1, {(ANGLE_BITS-1){1'b0}}});
    if (v > hi_lim) begin
      return hi_lim[ANGLE_BITS-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[ANGLE_BITS-1:0];
    end
    return v[ANGLE_BITS-1:0];
  endfunction

  // turn offset of candidate k, k = 0 is two turns back
  function automatic wide_t cand_offset(input logic [KSEL_BITS-1:0] k);
    wide_t off;
    unique case (k)
      KSEL_BITS'(0): off = -(TWO_PI_FX <<< 1);
      KSEL_BITS'(1): off = -TWO_PI_FX;
      KSEL_BITS'(3): off = TWO_PI_FX;
      KSEL_BITS'(4): off = TWO_PI_FX <<< 1;
      default:       off = '0;
    endcase
    return off;
  endfunction

endpackage

// File: rtl/joint_limit_align.sv
// joint limit align top level: limit memory and five-stage conditioning pipeline
//
// Input channel in_valid/in_stall/in_data carries one command for one joint.
// A load command writes that joint's lower and upper limit into the limit
// memory in the cycle it is accepted and gives no result; a following item
// for the same joint already sees the new limits. Clamp, clamp with rebound
// and align each give one item on out_valid/out_stall/out_data, in order.
// An accepted item passes five registers on its way to the output (memory read,
// limit compares, candidate selection, reciprocal multiply for the rebound tenth,
// output register). Throughput is one item per cycle, loads included, while
// the pipeline is not held full by a stalling receiver.
// When the receiver stalls, the output register holds its item and the
// stages behind it keep filling; in_stall rises only once every stage holds
// an item. Reset empties the pipeline and returns all limits to -2*pi and
// +2*pi at once through per-entry valid flags, so items are taken in the
// first cycle after reset.
module joint_limit_align import jla_pkg::*; #(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int MEM_DEPTH = (JOINT_COUNT < (1 << JOINT_BITS)) ? JOINT_COUNT
                                                               : (1 << JOINT_BITS);
  localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // handshake and stage occupancy
  logic in_acc;
  logic joint_ok;
  logic is_load;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic free1, free2, free3, free4, free_out;

  assign is_load  = (in_data.command == CMD_LOAD);
  assign joint_ok = int'(in_data.joint_index) < MEM_DEPTH;
  assign in_acc   = in_valid && !in_stall;

  assign free_out = !out_valid_r || !out_stall;
  assign free4    = !s4_v_r || free_out;
  assign free3    = !s3_v_r || free4;
  assign free2    = !s2_v_r || free3;
  assign free1    = !s1_v_r || free2;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free1)    s1_v_r      <= in_acc && !is_load;
      if (free2)    s2_v_r      <= s1_v_r;
      if (free3)    s3_v_r      <= s2_v_r;
      if (free4)    s4_v_r      <= s3_v_r;
      if (free_out) out_valid_r <= s4_v_r;
    end
  end

  // limit memory
  angle_t mem_lo;
  angle_t mem_hi;

  jla_limit_mem #(
    .DEPTH     (MEM_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc && is_load && joint_ok),
    .wr_addr (in_data.joint_index[ADDR_BITS-1:0]),
    .wr_lo   (in_data.new_lower),
    .wr_hi   (in_data.new_upper),
    .rd_en   (in_acc && !is_load && joint_ok),
    .rd_addr (in_data.joint_index[ADDR_BITS-1:0]),
    .rd_lo   (mem_lo),
    .rd_hi   (mem_hi)
  );

  // stage 1: item fields alongside the memory read
  cmd_t                  s1_cmd_r;
  logic [JOINT_BITS-1:0] s1_joint_r;
  logic                  s1_ok_r;
  angle_t                s1_ang_r;
  angle_t                s1_ref_r;

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_cmd_r   <= in_data.command;
      s1_joint_r <= in_data.joint_index;
      s1_ok_r    <= joint_ok;
      s1_ang_r   <= in_data.angle_in;
      s1_ref_r   <= in_data.reference_angle;
    end
  end

  // stage 2: limit compares, clamp, rebound excess, align distances
  wide_t                  v_w, lo_w, hi_w, ref_w, range_w, ex_w;
  logic                   s2_below_nxt, s2_above_nxt;
  angle_t                 s2_clamp_nxt;
  wide_t                  s2_m_nxt;
  logic [CAND_COUNT-1:0]  s2_inlim_nxt;
  logic [WIDE_BITS-1:0]   s2_dist_nxt [CAND_COUNT];

  always_comb begin
    wide_t cand;
    wide_t diff;
    v_w   = widen(s1_ang_r);
    lo_w  = widen(mem_lo);
    hi_w  = widen(mem_hi);
    ref_w = widen(s1_ref_r);
    s2_below_nxt = v_w < lo_w;
    s2_above_nxt = v_w > hi_w;
    s2_clamp_nxt = s2_below_nxt ? mem_lo : s1_ang_r;
    if (s2_clamp_nxt > mem_hi) begin
      s2_clamp_nxt = mem_hi;
    end
    range_w  = hi_w - lo_w;
    ex_w     = s2_below_nxt ? (lo_w - v_w) : (v_w - hi_w);
    s2_m_nxt = (ex_w < range_w) ? ex_w : range_w;
    for (int i = 0; i < CAND_COUNT; i++) begin
      cand = v_w + cand_offset(KSEL_BITS'(i));
      diff = cand - ref_w;
      s2_inlim_nxt[i] = (cand >= lo_w) && (cand <= hi_w);
      s2_dist_nxt[i]  = diff[WIDE_BITS-1] ? -diff : diff;
    end
  end

  cmd_t                  s2_cmd_r;
  logic [JOINT_BITS-1:0] s2_joint_r;
  logic                  s2_ok_r;
  angle_t                s2_ang_r, s2_lo_r, s2_hi_r, s2_clamp_r;
  logic                  s2_below_r, s2_above_r;
  wide_t                 s2_m_r;
  logic [CAND_COUNT-1:0] s2_inlim_r;
  logic [WIDE_BITS-1:0]  s2_dist_r [CAND_COUNT];

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_joint_r <= s1_joint_r;
      s2_ok_r    <= s1_ok_r;
      s2_ang_r   <= s1_ang_r;
      s2_lo_r    <= mem_lo;
      s2_hi_r    <= mem_hi;
      s2_clamp_r <= s2_clamp_nxt;
      s2_below_r <= s2_below_nxt;
      s2_above_r <= s2_above_nxt;
      s2_m_r     <= s2_m_nxt;
      s2_inlim_r <= s2_inlim_nxt;
      s2_dist_r  <= s2_dist_nxt;
    end
  end

  // stage 3: nearest in-limit candidate, rebound magnitude halved
  logic [KSEL_BITS-1:0] s3_ksel_nxt;
  logic                 s3_mneg_nxt;
  logic [31:0]          s3_y_nxt;

  always_comb begin
    logic [WIDE_BITS-1:0] best_d;
    wide_t                m_abs;
    wide_t                plus5;
    // unshifted angle is the starting pick, ties keep the earlier one
    s3_ksel_nxt = KSEL_CENTER;
    best_d      = s2_dist_r[KSEL_CENTER];
    for (int i = 0; i < CAND_COUNT; i++) begin
      if (s2_inlim_r[i] && (s2_dist_r[i] < best_d)) begin
        best_d      = s2_dist_r[i];
        s3_ksel_nxt = KSEL_BITS'(i);
      end
    end
    s3_mneg_nxt = s2_m_r[WIDE_BITS-1];
    m_abs       = s3_mneg_nxt ? -s2_m_r : s2_m_r;
    plus5       = m_abs + WIDE_BITS'(5);
    s3_y_nxt    = plus5[32:1];
  end

  cmd_t                  s3_cmd_r;
  logic [JOINT_BITS-1:0] s3_joint_r;
  logic                  s3_ok_r;
  angle_t                s3_ang_r, s3_lo_r, s3_hi_r, s3_clamp_r;
  logic                  s3_below_r, s3_above_r, s3_mneg_r;
  logic [31:0]           s3_y_r;
  logic [KSEL_BITS-1:0]  s3_ksel_r;

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_cmd_r   <= s2_cmd_r;
      s3_joint_r <= s2_joint_r;
      s3_ok_r    <= s2_ok_r;
      s3_ang_r   <= s2_ang_r;
      s3_lo_r    <= s2_lo_r;
      s3_hi_r    <= s2_hi_r;
      s3_clamp_r <= s2_clamp_r;
      s3_below_r <= s2_below_r;
      s3_above_r <= s2_above_r;
      s3_mneg_r  <= s3_mneg_nxt;
      s3_y_r     <= s3_y_nxt;
      s3_ksel_r  <= s3_ksel_nxt;
    end
  end

  // stage 4: divide by five through the reciprocal, align clamp
  logic [63:0] s4_prod_nxt;
  angle_t      s4_align_nxt;

  always_comb begin
    wide_t best;
    s4_prod_nxt = {32'd0, s3_y_r} * {32'd0, RECIP_FIVE};
    best = widen(s3_ang_r) + cand_offset(s3_ksel_r);
    if (best < widen(s3_lo_r)) begin
      best = widen(s3_lo_r);
    end
    if (best > widen(s3_hi_r)) begin
      best = widen(s3_hi_r);
    end
    s4_align_nxt = best[ANGLE_BITS-1:0];
  end

  cmd_t                  s4_cmd_r;
  logic [JOINT_BITS-1:0] s4_joint_r;
  logic                  s4_ok_r;
  angle_t                s4_ang_r, s4_base_r, s4_clamp_r, s4_align_r;
  logic                  s4_below_r, s4_above_r, s4_mneg_r;
  logic [63:0]           s4_prod_r;

  always_ff @(posedge clk) begin
    if (free4) begin
      s4_cmd_r   <= s3_cmd_r;
      s4_joint_r <= s3_joint_r;
      s4_ok_r    <= s3_ok_r;
      s4_ang_r   <= s3_ang_r;
      s4_base_r  <= s3_below_r ? s3_lo_r : s3_hi_r;
      s4_clamp_r <= s3_clamp_r;
      s4_align_r <= s4_align_nxt;
      s4_below_r <= s3_below_r;
      s4_above_r <= s3_above_r;
      s4_mneg_r  <= s3_mneg_r;
      s4_prod_r  <= s4_prod_nxt;
    end
  end

  // stage 5: finish rebound, pick the result per command
  angle_t out_angle_nxt;

  always_comb begin
    wide_t tenth_w;
    wide_t reb_w;
    tenth_w = wide_t'({{(WIDE_BITS-QUO_BITS){1'b0}}, s4_prod_r[63:RECIP_SHIFT]});
    if (s4_mneg_r) begin
      tenth_w = -tenth_w;
    end
    priority if (s4_below_r) begin
      reb_w = widen(s4_base_r) + tenth_w;
    end else if (s4_above_r) begin
      reb_w = widen(s4_base_r) - tenth_w;
    end else begin
      reb_w = widen(s4_ang_r);
    end
    unique case (s4_cmd_r)
      CMD_CLAMP:   out_angle_nxt = s4_clamp_r;
      CMD_REBOUND: out_angle_nxt = sat_angle(reb_w);
      CMD_ALIGN:   out_angle_nxt = s4_align_r;
      default:     out_angle_nxt = s4_ang_r;
    endcase
    // joint outside the table passes the angle through
    if (!s4_ok_r) begin
      out_angle_nxt = s4_ang_r;
    end
  end

  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (free_out) begin
      out_data_r.angle_out <= out_angle_nxt;
      out_data_r.joint_out <= s4_joint_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command == CMD_LOAD) |=> !s1_v_r)
    else $error("load item took a pipeline slot");

  a_item_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command != CMD_LOAD) |=> s1_v_r)
    else $error("accepted item lost before stage one");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input accepted while every stage is full");

  a_clamp_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && (s2_lo_r <= s2_hi_r)) |-> ((s2_clamp_r >= s2_lo_r) && (s2_clamp_r <= s2_hi_r)))
    else $error("clamp result outside ordered limits");

endmodule

// File: rtl/jla_limit_mem.sv
// per-joint lower/upper limit memory with registered read and reset-valid flags
module jla_limit_mem import jla_pkg::*; #(
  parameter int DEPTH     = JOINT_COUNT_DEF,
  parameter int ADDR_BITS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  angle_t               wr_lo,
  input  angle_t               wr_hi,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output angle_t               rd_lo,
  output angle_t               rd_hi
);

  angle_t           lo_mem [DEPTH];
  angle_t           hi_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  angle_t           lo_raw_r;
  angle_t           hi_raw_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lo_mem[wr_addr] <= wr_lo;
      hi_mem[wr_addr] <= wr_hi;
    end
  end

  // entries never loaded since reset read as the default limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lo_raw_r <= lo_mem[rd_addr];
      hi_raw_r <= hi_mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_lo = rd_vld_r ? lo_raw_r : LIMIT_LO_RST;
  assign rd_hi = rd_vld_r ? hi_raw_r : LIMIT_HI_RST;

endmodule

// File: verif/joint_limit_align_checker.sv
// checker for joint_limit_align: limit table predictor and in-order result compare
`timescale 1ns / 100ps
module joint_limit_align_checker import jla_pkg::*; #(
  parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        pending_count
);

  localparam longint FULL_TURN = 64'sd105414357;
  localparam longint ANGLE_MAX = (64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1;
  localparam longint ANGLE_MIN = -ANGLE_MAX - 64'sd1;

  longint    lower_tab [JOINT_COUNT];
  longint    upper_tab [JOINT_COUNT];
  out_item_t conditioned_q [$];

  function automatic longint sat_wide(input longint v);
    if (v > ANGLE_MAX) return ANGLE_MAX;
    if (v < ANGLE_MIN) return ANGLE_MIN;
    return v;
  endfunction

  function automatic longint clamp_fx(input longint v, input longint lo, input longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // exact tenth, rounded to nearest, ties away from zero
  function automatic longint tenth_round(input longint m);
    if (m >= 0) return (m + 5) / 10;
    return -((-m + 5) / 10);
  endfunction

  function automatic longint rebound_fx(input longint v, input longint lo, input longint hi);
    longint span;
    longint excess;
    span = hi - lo;
    if (v < lo) begin
      excess = lo - v;
      return lo + tenth_round((excess < span) ? excess : span);
    end
    if (v > hi) begin
      excess = v - hi;
      return hi - tenth_round((excess < span) ? excess : span);
    end
    return v;
  endfunction

  // unshifted angle is the starting best even when it lies outside the limits
  function automatic longint align_fx(input longint v, input longint target,
                                      input longint lo, input longint hi);
    longint best;
    longint near_gap;
    longint cand;
    longint cand_gap;
    best     = v;
    near_gap = (v - target < 0) ? target - v : v - target;
    for (int k = -2; k <= 2; k++) begin
      cand = v + FULL_TURN * longint'(k);
      if (cand >= lo && cand <= hi) begin
        cand_gap = (cand - target < 0) ? target - cand : cand - target;
        if (cand_gap < near_gap) begin
          near_gap = cand_gap;
          best     = cand;
        end
      end
    end
    return clamp_fx(best, lo, hi);
  endfunction

  function automatic out_item_t predict_conditioned(input in_item_t it);
    out_item_t res;
    longint    q;
    longint    r;
    longint    lo;
    longint    hi;
    q = longint'(it.angle_in);
    r = q;
    if (it.joint_index < JOINT_COUNT) begin
      lo = lower_tab[it.joint_index];
      hi = upper_tab[it.joint_index];
      case (it.command)
        CMD_CLAMP:   r = clamp_fx(q, lo, hi);
        CMD_REBOUND: r = rebound_fx(q, lo, hi);
        CMD_ALIGN:   r = align_fx(q, longint'(it.reference_angle), lo, hi);
        default:     r = q;
      endcase
    end
    res.angle_out = angle_t'(sat_wide(r));
    res.joint_out = it.joint_index;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        lower_tab[i] = sat_wide(-FULL_TURN);
        upper_tab[i] = sat_wide(FULL_TURN);
      end
      conditioned_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (conditioned_q.size() == 0) begin
          $error("unexpected result item: angle_out %0d joint_out %0d",
                 out_data.angle_out, out_data.joint_out);
          mismatch_count++;
        end else begin
          want = conditioned_q.pop_front();
          if (out_data.angle_out !== want.angle_out) begin
            $error("angle_out expected %0d actual %0d", want.angle_out, out_data.angle_out);
            mismatch_count++;
          end
          if (out_data.joint_out !== want.joint_out) begin
            $error("joint_out expected %0d actual %0d", want.joint_out, out_data.joint_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_LOAD) begin
          if (in_data.joint_index < JOINT_COUNT) begin
            lower_tab[in_data.joint_index] = longint'(in_data.new_lower);
            upper_tab[in_data.joint_index] = longint'(in_data.new_upper);
          end
        end else begin
          conditioned_q = {conditioned_q, predict_conditioned(in_data)};
        end
      end
    end
    pending_count <= conditioned_q.size();
  end

endmodule

// File: verif/joint_limit_align_tb.sv
// testbench top for joint_limit_align: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module joint_limit_align_tb;
  import jla_pkg::*;

  localparam int     TURN       = 105414357;
  localparam angle_t MAXA       = 32'sh7fff_ffff;
  localparam angle_t MINA       = 32'sh8000_0000;
  localparam int     RAND_ITEMS = 1800;
  localparam int     QUIET_FROM = 1500;
  localparam int     LONG_HOLD  = 60;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        mismatch_count;
  int        pending_count;

  bit     tx_idle;
  bit     rx_idle;
  int     hold_req;
  int     hold_done;
  // limits as last loaded, used only to aim angles near the edges
  angle_t stim_lo [8];
  angle_t stim_hi [8];

  joint_limit_align uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  joint_limit_align_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: long hold on request, otherwise random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_done++;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic angle_t clip_angle(input longint v);
    if (v > longint'(MAXA)) return MAXA;
    if (v < longint'(MINA)) return MINA;
    return angle_t'(v);
  endfunction

  function automatic in_item_t make_item(input cmd_t cmd, input int joint, input angle_t ang,
                                         input angle_t target, input angle_t lo,
                                         input angle_t hi);
    in_item_t it;
    it.command         = cmd;
    it.joint_index     = JOINT_BITS'(joint);
    it.angle_in        = ang;
    it.reference_angle = target;
    it.new_lower       = lo;
    it.new_upper       = hi;
    return it;
  endfunction

  function automatic angle_t span_angle();
    return angle_t'(int'($urandom_range(0, 6 * TURN)) - 3 * TURN);
  endfunction

  function automatic angle_t gen_angle(input int joint);
    longint edge_val;
    case ($urandom_range(0, 9))
      0, 1: return angle_t'($urandom);
      2: begin
        case ($urandom_range(0, 7))
          0: return MINA;
          1: return MAXA;
          2: return '0;
          3: return 32'sd1;
          4: return -32'sd1;
          5: return angle_t'(TURN);
          6: return -angle_t'(TURN);
          default: return angle_t'(2 * TURN);
        endcase
      end
      3, 4, 5, 6: begin
        edge_val = $urandom_range(0, 1) ? longint'(stim_lo[joint]) : longint'(stim_hi[joint]);
        if ($urandom_range(0, 2) == 0)
          edge_val += $urandom_range(0, 1) ? longint'(TURN) : -longint'(TURN);
        return clip_angle(edge_val + longint'($urandom_range(0, 6_000_000)) - 3_000_000);
      end
      default: return span_angle();
    endcase
  endfunction

  function automatic in_item_t gen_random_item();
    in_item_t it;
    int       joint;
    angle_t   lo;
    angle_t   hi;
    angle_t   tmp;
    joint = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    it = make_item(cmd_t'($urandom_range(0, 2)), joint, gen_angle(joint), angle_t'($urandom),
                   angle_t'($urandom), angle_t'($urandom));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: it.reference_angle = clip_angle(longint'(it.angle_in) +
                                                     longint'(span_angle()) / 3);
      5, 6, 7: it.reference_angle = span_angle();
      default: ;
    endcase
    if ($urandom_range(0, 99) < 15) begin
      it.command = CMD_LOAD;
      case ($urandom_range(0, 19))
        14, 15: begin
          lo = span_angle();
          hi = span_angle();
          if (lo < hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        16: begin
          lo = span_angle();
          hi = lo;
        end
        17: begin
          lo = $urandom_range(0, 1) ? MINA : MAXA;
          hi = (lo == MINA) ? MAXA : MINA;
        end
        18, 19: begin
          lo = angle_t'($urandom);
          hi = angle_t'($urandom);
        end
        default: begin
          lo = angle_t'(int'($urandom_range(0, 4 * TURN)) - 3 * TURN);
          hi = clip_angle(longint'(lo) + longint'($urandom_range(0, 3 * TURN)));
        end
      endcase
      it.new_lower = lo;
      it.new_upper = hi;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.command == CMD_LOAD && it.joint_index < JOINT_COUNT_DEF) begin
      stim_lo[it.joint_index] = it.new_lower;
      stim_hi[it.joint_index] = it.new_upper;
    end
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering items until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int guard;
    for (int i = 0; i < 8; i++) begin
      stim_lo[i] = LIMIT_LO_RST;
      stim_hi[i] = LIMIT_HI_RST;
    end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits on joint 0
    send_item(make_item(CMD_CLAMP,   0, MAXA, '0, '0, '0));
    send_item(make_item(CMD_CLAMP,   0, MINA, '0, '0, '0));
    send_item(make_item(CMD_CLAMP,   0, 32'sd12345, '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 0, angle_t'(TURN + 1000), '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 0, MAXA, '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 0, -angle_t'(TURN + 7), '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 0, MINA, '0, '0, '0));
    send_item(make_item(CMD_ALIGN,   0, 32'sd150000000, '0, '0, '0));
    send_item(make_item(CMD_ALIGN,   0, 32'sd10, MAXA, '0, '0));
    // just either side of the midpoint between two candidates
    send_item(make_item(CMD_ALIGN,   0, '0, angle_t'((TURN - 1) / 2), '0, '0));
    send_item(make_item(CMD_ALIGN,   0, '0, angle_t'((TURN + 1) / 2), '0, '0));
    // align with no candidate inside narrow limits
    send_item(make_item(CMD_LOAD,    1, '0, '0, '0, 32'sd1000));
    send_item(make_item(CMD_ALIGN,   1, 32'sh4000_0000, '0, '0, '0));
    // inverted limits
    send_item(make_item(CMD_LOAD,    2, '0, '0, 32'sd1000, -32'sd1000));
    send_item(make_item(CMD_CLAMP,   2, '0, '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 2, 32'sd5000, '0, '0, '0));
    send_item(make_item(CMD_ALIGN,   2, 32'sd200, -32'sd200, '0, '0));
    // full-range and inverted full-range limits
    send_item(make_item(CMD_LOAD,    3, '0, '0, MINA, MAXA));
    send_item(make_item(CMD_ALIGN,   3, MAXA, MINA, '0, '0));
    send_item(make_item(CMD_REBOUND, 3, MINA, '0, '0, '0));
    send_item(make_item(CMD_LOAD,    4, '0, '0, MAXA, MINA));
    send_item(make_item(CMD_REBOUND, 4, '0, '0, '0, '0));
    // zero range
    send_item(make_item(CMD_LOAD,    5, '0, '0, 32'sd500, 32'sd500));
    send_item(make_item(CMD_REBOUND, 5, 32'sd600, '0, '0, '0));
    // joints past the table: load ignored, angle passes through
    send_item(make_item(CMD_LOAD,    6, '0, '0, '0, '0));
    send_item(make_item(CMD_CLAMP,   6, MAXA, '0, '0, '0));
    send_item(make_item(CMD_REBOUND, 7, MINA, '0, '0, '0));
    send_item(make_item(CMD_ALIGN,   7, 32'sd77, MAXA, '0, '0));
    drain_results();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400 || n == 1100) begin
        // receiver holds off while the sender keeps the input busy
        hold_req++;
        tx_idle = 1'b0;
      end
      if (n == 480 || n == 1180) tx_idle = 1'b1;
      if (n == 900) drain_results();
      if (n == QUIET_FROM) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      send_item(gen_random_item());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending_count != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_count != 0)
      $error("%0d result items never arrived", pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: joint_limit_align.f
rtl/jla_pkg.sv
rtl/jla_limit_mem.sv
rtl/joint_limit_align.sv
verif/joint_limit_align_checker.sv
verif/joint_limit_align_tb.sv
